/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the rtl files
// both sample on clk_i and stay quiet while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tgse_pkg.sv */
`timescale 1ns / 1ps
package tgse_pkg;

  // cell grid limits
  localparam int unsigned MaxColumns = 80;
  localparam int unsigned MaxRows    = 120;
  localparam int unsigned PosW       = 7;

  // byte codes of the glyph stream
  localparam logic [7:0] NewRowByte  = 8'd13;
  localparam logic [7:0] EndByte     = 8'd0;
  localparam logic [7:0] BlankByte   = 8'h20;
  localparam logic [7:0] OutlineFirst = 8'd65;
  localparam logic [7:0] OutlineLast  = 8'd81;

  // outline rom geometry
  localparam int unsigned OutlineStyles = 19;
  localparam int unsigned OutlineCodes  = 17;
  localparam int unsigned StyleW        = 5;
  localparam int unsigned CodeW         = 5;
  localparam logic [StyleW-1:0] LastStyle = StyleW'(OutlineStyles - 1);

  // configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] RegFontMode     = 1'b0;
  localparam logic [CfgIdxW-1:0] RegOutlineStyle = 1'b1;

  typedef enum logic [1:0] {
    MODE_OUTLINE = 2'd0,
    MODE_BLOCK   = 2'd1,
    MODE_COLOR   = 2'd2,
    MODE_SPARE   = 2'd3
  } font_mode_e;

  typedef enum logic [1:0] {
    KIND_CELL = 2'd0,
    KIND_SIZE = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PH_WIDTH  = 3'd0,
    PH_HEIGHT = 3'd1,
    PH_FIRST  = 3'd2,
    PH_CHAR   = 3'd3,
    PH_COLOR  = 3'd4
  } phase_e;

  typedef struct packed {
    kind_e            kind;
    logic [PosW-1:0]  row;
    logic [PosW-1:0]  column;
    logic [7:0]       glyph_char;
    logic [7:0]       attribute;
    logic [7:0]       glyph_width;
    logic [7:0]       glyph_height;
  } result_t;

  // box drawing characters, one row per outline style
  localparam logic [7:0] OUTLINE_ROM [OutlineStyles][OutlineCodes] = '{
    '{8'hC4,8'hC4,8'hB3,8'hB3,8'hDA,8'hBF,8'hDA,8'hBF,8'hC0,8'hD9,8'hC0,8'hD9,8'hB4,8'hC3,
      8'h20,8'h20,8'h20},
    '{8'hCD,8'hC4,8'hB3,8'hB3,8'hD5,8'hB8,8'hDA,8'hBF,8'hD4,8'hBE,8'hC0,8'hD9,8'hB5,8'hC3,
      8'h20,8'h20,8'h20},
    '{8'hC4,8'hCD,8'hB3,8'hB3,8'hDA,8'hBF,8'hD5,8'hB8,8'hC0,8'hD9,8'hD4,8'hBE,8'hB4,8'hC6,
      8'h20,8'h20,8'h20},
    '{8'hCD,8'hCD,8'hB3,8'hB3,8'hD5,8'hB8,8'hD5,8'hB8,8'hD4,8'hBE,8'hD4,8'hBE,8'hB5,8'hC6,
      8'h20,8'h20,8'h20},
    '{8'hC4,8'hC4,8'hBA,8'hB3,8'hD6,8'hBF,8'hDA,8'hB7,8'hC0,8'hBD,8'hD3,8'hD9,8'hB6,8'hC3,
      8'h20,8'h20,8'h20},
    '{8'hCD,8'hC4,8'hBA,8'hB3,8'hC9,8'hB8,8'hDA,8'hB7,8'hD4,8'hBC,8'hD3,8'hD9,8'hB9,8'hC3,
      8'h20,8'h20,8'h20},
    '{8'hC4,8'hCD,8'hBA,8'hB3,8'hD6,8'hBF,8'hD5,8'hBB,8'hC0,8'hBD,8'hC8,8'hBE,8'hB6,8'hC6,
      8'h20,8'h20,8'h20},
    '{8'hCD,8'hCD,8'hBA,8'hB3,8'hC9,8'hB8,8'hD5,8'hBB,8'hD4,8'hBC,8'hC8,8'hBE,8'hB9,8'hC6,
      8'h20,8'h20,8'h20},
    '{8'hC4,8'hC4,8'hB3,8'hBA,8'hDA,8'hB7,8'hD6,8'hBF,8'hD3,8'hD9,8'hC0,8'hBD,8'hB4,8'hC7,
      8'h20,8'h20,8'h20},
    '{8'hCD,8'hC4,8'hB3,8'hBA,8'hD5,8'hBB,8'hD6,8'hBF,8'hC8,8'hBE,8'hC0,8'hBD,8'hB5,8'hC7,
      8'h20,8'h20,8'h20},
    '{8'hC4,8'hCD,8'hB3,8'hBA,8'hDA,8'hB7,8'hC9,8'hB8,8'hD3,8'hD9,8'hD4,8'hBC,8'hB4,8'hCC,
      8'h20,8'h20,8'h20},
    '{8'hCD,8'hCD,8'hB3,8'hBA,8'hD5,8'hBB,8'hC9,8'hB8,8'hC8,8'hBE,8'hD4,8'hBC,8'hB5,8'hCC,
      8'h20,8'h20,8'h20},
    '{8'hC4,8'hC4,8'hBA,8'hBA,8'hD6,8'hB7,8'hD6,8'hB7,8'hD3,8'hBD,8'hD3,8'hBD,8'hB6,8'hC7,
      8'h20,8'h20,8'h20},
    '{8'hCD,8'hC4,8'hBA,8'hBA,8'hC9,8'hBB,8'hD6,8'hB7,8'hC8,8'hBC,8'hD3,8'hBD,8'hB9,8'hC7,
      8'h20,8'h20,8'h20},
    '{8'hC4,8'hCD,8'hBA,8'hBA,8'hD6,8'hB7,8'hC9,8'hBB,8'hD3,8'hBD,8'hC8,8'hBC,8'hB6,8'hCC,
      8'h20,8'h20,8'h20},
    '{8'hCD,8'hCD,8'hBA,8'hBA,8'hC9,8'hBB,8'hC9,8'hBB,8'hC8,8'hBC,8'hC8,8'hBC,8'hB9,8'hCC,
      8'h20,8'h20,8'h20},
    '{8'hDC,8'hDC,8'hDB,8'hDB,8'hDC,8'hDC,8'hDC,8'hDC,8'hDB,8'hDB,8'hDB,8'hDB,8'hDB,8'hDB,
      8'h20,8'h20,8'h20},
    '{8'hDF,8'hDF,8'hDB,8'hDB,8'hDB,8'hDB,8'hDB,8'hDB,8'hDF,8'hDF,8'hDF,8'hDF,8'hDB,8'hDB,
      8'h20,8'h20,8'h20},
    '{8'hDF,8'hDC,8'hDE,8'hDD,8'hDE,8'hDD,8'hDC,8'hDC,8'hDF,8'hDF,8'hDE,8'hDD,8'hDB,8'hDB,
      8'h20,8'h20,8'h20}
  };

  // outline mapping: codes outside the drawing range become blanks
  function automatic logic [7:0] map_outline(logic [StyleW-1:0] style, logic [7:0] b);
    logic [StyleW-1:0] sat_style;
    logic [7:0]        offset;
    sat_style = (style > LastStyle) ? LastStyle : style;
    offset    = b - OutlineFirst;
    if (b >= OutlineFirst && b <= OutlineLast) begin
      return OUTLINE_ROM[sat_style][offset[CodeW-1:0]];
    end
    return BlankByte;
  endfunction

endpackage

/* hw/rtl/tgse_intf.sv */
`timescale 1ns / 1ps
// glyph byte channel
interface tgse_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// result channel
interface tgse_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [6:0] row;
  logic [6:0] column;
  logic [7:0] glyph_char;
  logic [7:0] attribute;
  logic [7:0] glyph_width;
  logic [7:0] glyph_height;

  modport source (output valid, output kind, output row, output column, output glyph_char,
                  output attribute, output glyph_width, output glyph_height, input ready);
  modport sink (input valid, input kind, input row, input column, input glyph_char,
                input attribute, input glyph_width, input glyph_height, output ready);
endinterface

// configuration write channel
interface tgse_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/text_glyph_stream_expander.sv */
`timescale 1ns / 1ps
// Glyph byte stream to text cell writes. One byte is taken every clock cycle unless both
// entries of the two-entry output buffer hold untaken results. A byte's result, if any (a
// size report after the height byte, a cell write, or an end marker), is registered in that
// buffer and reaches the output after any older result is taken. Configuration writes (font
// mode, outline style) are taken in any cycle and should only be issued between glyphs.
module text_glyph_stream_expander (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tgse_byte_if.sink            in_i,
  tgse_result_if.source        out_o,
  tgse_cfg_if.sink             cfg_i
);
  import tgse_pkg::*;

  logic    space;
  logic    res_valid;
  result_t res;
  result_t head;

  assign cfg_i.ready = 1'b1;

  tgse_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .beat_valid_i (in_i.valid),
    .data_byte_i  (in_i.data_byte),
    .space_i      (space),
    .beat_ready_o (in_i.ready),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  tgse_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (head)
  );

  // result fields onto the channel
  assign out_o.kind         = head.kind;
  assign out_o.row          = head.row;
  assign out_o.column       = head.column;
  assign out_o.glyph_char   = head.glyph_char;
  assign out_o.attribute    = head.attribute;
  assign out_o.glyph_width  = head.glyph_width;
  assign out_o.glyph_height = head.glyph_height;

endmodule

/* hw/rtl/tgse_core.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tgse_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [tgse_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tgse_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          beat_valid_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          space_i,
  output logic                          beat_ready_o,
  output logic                          res_valid_o,
  output tgse_pkg::result_t             res_o
);
  import tgse_pkg::*;

  font_mode_e        font_mode_q;
  logic [StyleW-1:0] style_q;
  phase_e            phase_q, phase_d;
  logic [7:0]        held_width_q, held_width_d;
  logic [PosW-1:0]   col_q, col_d;
  logic [PosW-1:0]   row_q, row_d;
  logic [7:0]        pend_q, pend_d;
  logic              accept;
  logic              is_char_pos;
  logic              is_end;
  logic              in_range;
  logic              put_req;
  logic [7:0]        put_char;
  logic [7:0]        put_attr;

  assign beat_ready_o = space_i;
  assign accept       = beat_valid_i && space_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      font_mode_q <= MODE_OUTLINE;
      style_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegFontMode:     font_mode_q <= font_mode_e'(cfg_data_i[1:0]);
        RegOutlineStyle: style_q     <= cfg_data_i[StyleW-1:0];
        default: ;
      endcase
    end
  end

  assign is_char_pos = (phase_q == PH_FIRST) || (phase_q == PH_CHAR);
  assign is_end      = (phase_q == PH_CHAR) && (data_byte_i == EndByte);
  assign in_range    = (col_q < PosW'(MaxColumns)) && (row_q < PosW'(MaxRows));

  // phase sequencing
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_WIDTH:  phase_d = PH_HEIGHT;
      PH_HEIGHT: phase_d = PH_FIRST;
      PH_COLOR:  phase_d = PH_CHAR;
      PH_FIRST, PH_CHAR: begin
        if (is_end) begin
          phase_d = PH_WIDTH;
        end else if (data_byte_i != NewRowByte && font_mode_q == MODE_COLOR) begin
          phase_d = PH_COLOR;
        end else begin
          phase_d = PH_CHAR;
        end
      end
      default: phase_d = PH_WIDTH;
    endcase
  end

  // cell choice and cursor updates
  always_comb begin
    held_width_d = held_width_q;
    col_d        = col_q;
    row_d        = row_q;
    pend_d       = pend_q;
    put_req      = 1'b0;
    put_char     = data_byte_i;
    put_attr     = '0;
    if (phase_q == PH_WIDTH) begin
      held_width_d = data_byte_i;
      col_d        = '0;
      row_d        = '0;
    end else if (phase_q == PH_COLOR) begin
      put_req  = 1'b1;
      put_char = pend_q;
      put_attr = data_byte_i;
    end else if (is_char_pos) begin
      if (is_end) begin
        col_d = '0;
        row_d = '0;
      end else if (data_byte_i == NewRowByte) begin
        col_d = '0;
        if (row_q < PosW'(MaxRows)) begin
          row_d = row_q + 1'b1;
        end
      end else if (font_mode_q == MODE_COLOR) begin
        pend_d = data_byte_i;
      end else begin
        put_req = 1'b1;
        if (font_mode_q == MODE_OUTLINE) begin
          put_char = map_outline(style_q, data_byte_i);
        end
      end
    end
    if (put_req && in_range) begin
      col_d = col_q + 1'b1;
    end
  end

  // result of the current beat
  always_comb begin
    res_o       = '0;
    res_valid_o = 1'b0;
    if (accept) begin
      if (phase_q == PH_HEIGHT) begin
        res_valid_o        = 1'b1;
        res_o.kind         = KIND_SIZE;
        res_o.glyph_width  = held_width_q;
        res_o.glyph_height = data_byte_i;
      end else if (is_end) begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_END;
      end else if (put_req && in_range) begin
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_CELL;
        res_o.row        = row_q;
        res_o.column     = col_q;
        res_o.glyph_char = put_char;
        res_o.attribute  = put_attr;
      end
    end
  end

  // glyph state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_WIDTH;
      held_width_q <= '0;
      col_q        <= '0;
      row_q        <= '0;
      pend_q       <= '0;
    end else if (accept) begin
      phase_q      <= phase_d;
      held_width_q <= held_width_d;
      col_q        <= col_d;
      row_q        <= row_d;
      pend_q       <= pend_d;
    end
  end

  `ASSERT_ALWAYS(col_bound_a, col_q <= PosW'(MaxColumns), "column ran past the grid")
  `ASSERT_ALWAYS(row_bound_a, row_q <= PosW'(MaxRows), "row ran past saturation")
  `ASSERT_NEXT(width_to_height_a, accept && phase_q == PH_WIDTH,
               phase_q == PH_HEIGHT && col_q == '0 && row_q == '0,
               "width beat did not arm the height beat")
  `ASSERT_NEXT(end_restart_a, res_valid_o && res_o.kind == KIND_END,
               phase_q == PH_WIDTH, "end result did not return to the width beat")

endmodule

/* hw/rtl/tgse_out_buf.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tgse_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tgse_pkg::result_t push_data_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tgse_pkg::result_t out_data_o
);
  import tgse_pkg::*;

  result_t    slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign space_o     = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = slot_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  // occupancy
  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  // two result slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and occupancy count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

  `ASSERT_ALWAYS(no_overflow_a, !(push_i && count_q == 2'd2), "push into a full buffer")
  `ASSERT_ALWAYS(ptr_match_a, (count_q == 2'd1) == (wr_ptr_q != rd_ptr_q),
                 "pointers disagree with occupancy")
  `ASSERT_NEXT(hold_a, out_valid_o && !out_ready_i, out_valid_o,
               "stalled result was dropped")

endmodule
